### sv/mup_pkg.sv
// Package for the MIDI to USB-MIDI event packet encoder.
// Status codes, code index numbers, state and packet types, message length and code index helpers.
// No dependencies.
package mup_pkg;

	localparam logic [7:0] SYSEX_START  = 8'hF0;
	localparam logic [7:0] SYSEX_END    = 8'hF7;
	localparam logic [7:0] REALTIME_MIN = 8'hF8;
	localparam logic [7:0] SYS_STATUS   = 8'hF0;
	localparam logic [7:0] SYS_MTC      = 8'hF1;
	localparam logic [7:0] SYS_SONG_POS = 8'hF2;
	localparam logic [7:0] SYS_SONG_SEL = 8'hF3;
	localparam logic [7:0] CHAN_TYPE_MASK = 8'hE0;
	localparam logic [7:0] CHAN_TWO_BYTE  = 8'hC0;

	localparam logic [3:0] CIN_SYSCOM2    = 4'h2;
	localparam logic [3:0] CIN_SYSCOM3    = 4'h3;
	localparam logic [3:0] CIN_SYSEX_CONT = 4'h4;
	localparam logic [3:0] CIN_SYSEX_END1 = 4'h5;
	localparam logic [3:0] CIN_SYSEX_END2 = 4'h6;
	localparam logic [3:0] CIN_SYSEX_END3 = 4'h7;
	localparam logic [3:0] CIN_REALTIME   = 4'hF;

	typedef struct packed {
		logic       sysex_active;
		logic [1:0] sysex_held;
		logic [7:0] sysex_byte0;
		logic [7:0] sysex_byte1;
		logic [7:0] msg_status;
		logic [1:0] msg_remaining;
		logic [7:0] msg_first_data;
	} mup_state_t;

	typedef struct packed {
		logic [3:0] code_index;
		logic [7:0] msg_byte0;
		logic [7:0] msg_byte1;
		logic [7:0] msg_byte2;
	} mup_pkt_t;

	// total message length in bytes for a non-SysEx status
	function automatic logic [1:0] msg_length(input logic [7:0] st);
		logic [1:0] n;
		if (st < SYS_STATUS) begin
			n = ((st & CHAN_TYPE_MASK) == CHAN_TWO_BYTE) ? 2'd2 : 2'd3;
		end else if (st == SYS_MTC || st == SYS_SONG_SEL) begin
			n = 2'd2;
		end else if (st == SYS_SONG_POS) begin
			n = 2'd3;
		end else begin
			n = 2'd1;
		end
		return n;
	endfunction

	function automatic logic [3:0] msg_cin(input logic [7:0] st, input logic [1:0] n);
		logic [3:0] c;
		if (st < SYS_STATUS) begin
			c = st[7:4];
		end else if (st >= REALTIME_MIN) begin
			c = CIN_REALTIME;
		end else if (n == 2'd1) begin
			c = CIN_SYSEX_END1;
		end else if (n == 2'd2) begin
			c = CIN_SYSCOM2;
		end else begin
			c = CIN_SYSCOM3;
		end
		return c;
	endfunction

endpackage

### sv/mup_if.sv
// Valid/ready channel interfaces: raw MIDI bytes in, event packets out.
// No dependencies.
interface mup_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] midi_byte;
	logic       end_of_write;

	modport source (output valid, output midi_byte, output end_of_write, input ready);
	modport sink (input valid, input midi_byte, input end_of_write, output ready);
endinterface

interface mup_pkt_if;
	logic       valid;
	logic       ready;
	logic [3:0] code_index;
	logic [7:0] msg_byte0;
	logic [7:0] msg_byte1;
	logic [7:0] msg_byte2;

	modport source (output valid, output code_index, output msg_byte0, output msg_byte1,
		output msg_byte2, input ready);
	modport sink (input valid, input code_index, input msg_byte0, input msg_byte1,
		input msg_byte2, output ready);
endinterface

### sv/midi_to_usb_midi_packetizer_core.sv
// MIDI byte stream to USB-MIDI 1.0 event packet encoder, cable 0, top level.
// Flow: a byte accepted is held in the input stage; its packet, if any, is loaded
// into the result register when the byte retires and is offered from then on.
// Throughput: one byte per cycle, limited only by the result register draining.
// Reset (arst_n low, asynchronous): both stages empty, parser state cleared.
// Depends on mup_pkg, mup_if.sv (mup_byte_if, mup_pkt_if) and mup_encoder.
module midi_to_usb_midi_packetizer_core (
	input  logic           clk,
	input  logic           arst_n,
	mup_byte_if.sink       midi_in,
	mup_pkt_if.source      pkt_out
);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eow_s1;

	// parser state and result register
	mup_pkg::mup_state_t state_q;
	mup_pkg::mup_state_t state_nxt;
	logic                out_valid_q;
	mup_pkg::mup_pkt_t   out_pkt_q;

	logic              pkt_valid;
	mup_pkg::mup_pkt_t pkt;
	logic              out_free;
	logic              advance;
	logic              in_take;

	// The result register can be overwritten when empty or being taken this cycle.
	// The input stage retires its byte whenever the result register can absorb it,
	// whether or not the byte yields a packet.
	assign out_free = !out_valid_q || pkt_out.ready;
	assign advance  = valid_s1 && out_free;
	assign midi_in.ready = !valid_s1 || out_free;
	assign in_take  = midi_in.valid && midi_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= midi_in.midi_byte;
			eow_s1  <= midi_in.end_of_write;
		end
	end

	mup_encoder u_encoder (
		.cur          (state_q),
		.midi_byte    (byte_s1),
		.end_of_write (eow_s1),
		.nxt          (state_nxt),
		.pkt_valid    (pkt_valid),
		.pkt          (pkt)
	);

	// parser state steps once per retired byte; the whole state clears on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && pkt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && pkt_valid && out_free) begin
			out_pkt_q <= pkt;
		end
	end

	assign pkt_out.valid      = out_valid_q;
	assign pkt_out.code_index = out_pkt_q.code_index;
	assign pkt_out.msg_byte0  = out_pkt_q.msg_byte0;
	assign pkt_out.msg_byte1  = out_pkt_q.msg_byte1;
	assign pkt_out.msg_byte2  = out_pkt_q.msg_byte2;

endmodule

### sv/mup_encoder.sv
// Per-byte encoder step: next state and an optional event packet.
// Depends on mup_pkg.
module mup_encoder (
	input  mup_pkg::mup_state_t cur,
	input  logic [7:0]          midi_byte,
	input  logic                end_of_write,
	output mup_pkg::mup_state_t nxt,
	output logic                pkt_valid,
	output mup_pkg::mup_pkt_t   pkt
);

	logic       active;
	logic [1:0] held;
	logic [1:0] n;

	always_comb begin
		nxt       = cur;
		pkt_valid = 1'b0;
		pkt       = '0;
		active    = cur.sysex_active;
		held      = cur.sysex_held;
		n         = mup_pkg::msg_length(cur.msg_status);

		if (cur.msg_remaining != 2'd0) begin
			if (cur.msg_remaining >= 2'd2) begin
				nxt.msg_first_data = midi_byte;
				nxt.msg_remaining  = 2'd1;
			end else begin
				nxt.msg_remaining = 2'd0;
				pkt_valid         = 1'b1;
				pkt.code_index    = mup_pkg::msg_cin(cur.msg_status, n);
				pkt.msg_byte0     = cur.msg_status;
				if (n == 2'd2) begin
					pkt.msg_byte1 = midi_byte;
				end else begin
					pkt.msg_byte1 = cur.msg_first_data;
					pkt.msg_byte2 = midi_byte;
				end
			end
		end else begin
			if (!active && midi_byte == mup_pkg::SYSEX_START) begin
				active = 1'b1;
				held   = 2'd0;
			end
			if (active) begin
				if (midi_byte == mup_pkg::SYSEX_END) begin
					pkt_valid = 1'b1;
					case (held)
						2'd0: begin
							pkt.code_index = mup_pkg::CIN_SYSEX_END1;
							pkt.msg_byte0  = midi_byte;
						end
						2'd1: begin
							pkt.code_index = mup_pkg::CIN_SYSEX_END2;
							pkt.msg_byte0  = cur.sysex_byte0;
							pkt.msg_byte1  = midi_byte;
						end
						default: begin
							pkt.code_index = mup_pkg::CIN_SYSEX_END3;
							pkt.msg_byte0  = cur.sysex_byte0;
							pkt.msg_byte1  = cur.sysex_byte1;
							pkt.msg_byte2  = midi_byte;
						end
					endcase
					active = 1'b0;
					held   = 2'd0;
				end else if (held >= 2'd2) begin
					pkt_valid      = 1'b1;
					pkt.code_index = mup_pkg::CIN_SYSEX_CONT;
					pkt.msg_byte0  = cur.sysex_byte0;
					pkt.msg_byte1  = cur.sysex_byte1;
					pkt.msg_byte2  = midi_byte;
					held           = 2'd0;
				end else begin
					if (held == 2'd0) begin
						nxt.sysex_byte0 = midi_byte;
					end else begin
						nxt.sysex_byte1 = midi_byte;
					end
					// flush partial chunk at end of write
					if (end_of_write) begin
						pkt_valid      = 1'b1;
						pkt.code_index = mup_pkg::CIN_SYSEX_CONT;
						if (held == 2'd0) begin
							pkt.msg_byte0 = midi_byte;
						end else begin
							pkt.msg_byte0 = cur.sysex_byte0;
							pkt.msg_byte1 = midi_byte;
						end
					end
					held = held + 2'd1;
				end
			end else if (midi_byte[7]) begin
				if (mup_pkg::msg_length(midi_byte) == 2'd1) begin
					pkt_valid      = 1'b1;
					pkt.code_index = mup_pkg::msg_cin(midi_byte, 2'd1);
					pkt.msg_byte0  = midi_byte;
				end else begin
					nxt.msg_status    = midi_byte;
					nxt.msg_remaining = mup_pkg::msg_length(midi_byte) - 2'd1;
				end
			end
			nxt.sysex_active = active;
			nxt.sysex_held   = held;
		end

		// each write starts fresh
		if (end_of_write) begin
			nxt.sysex_active  = 1'b0;
			nxt.sysex_held    = 2'd0;
			nxt.msg_status    = 8'h00;
			nxt.msg_remaining = 2'd0;
		end
	end

endmodule

### sv/mup_checker.sv
// Port-level checks for the event packet encoder, bound to the top level.
// Depends on mup_pkg and midi_to_usb_midi_packetizer_core.
module mup_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] code_index,
	input logic [7:0] msg_byte0,
	input logic [7:0] msg_byte1,
	input logic [7:0] msg_byte2
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_index) && $stable(msg_byte0))
		else $error("stalled packet changed");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	a_realtime_pkt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && code_index == mup_pkg::CIN_REALTIME |->
			msg_byte0 >= mup_pkg::REALTIME_MIN && msg_byte1 == 8'h00 && msg_byte2 == 8'h00)
		else $error("bad real-time packet");

	a_sysex_end2: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && code_index == mup_pkg::CIN_SYSEX_END2 |->
			msg_byte1 == mup_pkg::SYSEX_END && msg_byte2 == 8'h00)
		else $error("bad two-byte SysEx end packet");

endmodule

bind midi_to_usb_midi_packetizer_core mup_checker u_mup_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (midi_in.ready),
	.out_valid  (pkt_out.valid),
	.out_ready  (pkt_out.ready),
	.code_index (pkt_out.code_index),
	.msg_byte0  (pkt_out.msg_byte0),
	.msg_byte1  (pkt_out.msg_byte1),
	.msg_byte2  (pkt_out.msg_byte2)
);

### dv/midi_to_usb_midi_packetizer_core_test.sv
// Testbench for midi_to_usb_midi_packetizer_core: drives MIDI byte writes and checks
// every USB-MIDI event packet against an in-bench parser kept in a scoreboard class.
// Depends on mup_pkg, mup_if.sv (mup_byte_if, mup_pkt_if) and the core RTL.
module midi_to_usb_midi_packetizer_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	// lowest status byte; anything below is data
	localparam logic [7:0] STATUS_MIN = 8'h80;
	// cycles with no transaction on either channel before the run is declared hung
	localparam int unsigned HANG_LIMIT = 2000;
	localparam int unsigned RANDOM_ITEMS = 1900;
	// the tail of the random part runs with no gaps and no stalls
	localparam int unsigned CALM_TAIL = 300;

	// Tracks the parser state of the encoder and queues the packets it should send.
	class packet_scoreboard;
		mup_pkg::mup_pkt_t expected_pkts[$];
		int unsigned fault_count;

		// parser copy
		bit         sx_on;
		bit [1:0]   sx_cnt;
		bit [7:0]   sx_buf[2];
		bit [7:0]   run_status;
		bit [1:0]   data_left;
		bit [7:0]   data1;

		function new();
			fault_count = 0;
			clear();
		endfunction

		function void clear();
			sx_on = 0;
			sx_cnt = 0;
			sx_buf[0] = 0;
			sx_buf[1] = 0;
			run_status = 0;
			data_left = 0;
			data1 = 0;
		endfunction

		function void fault(string text);
			fault_count++;
			if (fault_count <= 10)
				$display("%t ERROR %s", $realtime, text);
		endfunction

		function int unsigned pending();
			return expected_pkts.size();
		endfunction

		function int unsigned bytes_in_message(bit [7:0] st);
			if (st < mup_pkg::SYS_STATUS)
				return ((st & mup_pkg::CHAN_TYPE_MASK) == mup_pkg::CHAN_TWO_BYTE) ? 2 : 3;
			if (st == mup_pkg::SYS_MTC || st == mup_pkg::SYS_SONG_SEL)
				return 2;
			if (st == mup_pkg::SYS_SONG_POS)
				return 3;
			return 1;
		endfunction

		function bit [3:0] cin_for(bit [7:0] st, int unsigned n);
			if (st < mup_pkg::SYS_STATUS)
				return st[7:4];
			if (st >= mup_pkg::REALTIME_MIN)
				return mup_pkg::CIN_REALTIME;
			if (n == 1)
				return mup_pkg::CIN_SYSEX_END1;
			return (n == 2) ? mup_pkg::CIN_SYSCOM2 : mup_pkg::CIN_SYSCOM3;
		endfunction

		// one accepted byte; queues the packet it completes, if any
		function void note_byte(bit [7:0] b, bit eow);
			mup_pkg::mup_pkt_t p;
			bit          made;
			int unsigned n;
			made = 0;
			p = '0;
			if (data_left != 0) begin
				if (data_left >= 2) begin
					data1 = b;
					data_left = 1;
				end else begin
					n = bytes_in_message(run_status);
					data_left = 0;
					made = 1;
					if (n == 2)
						p = {cin_for(run_status, n), run_status, b, 8'h00};
					else
						p = {cin_for(run_status, n), run_status, data1, b};
				end
			end else begin
				if (!sx_on && b == mup_pkg::SYSEX_START) begin
					sx_on = 1;
					sx_cnt = 0;
				end
				if (sx_on) begin
					if (b == mup_pkg::SYSEX_END) begin
						made = 1;
						case (sx_cnt)
							2'd0: p = {mup_pkg::CIN_SYSEX_END1, b, 8'h00, 8'h00};
							2'd1: p = {mup_pkg::CIN_SYSEX_END2, sx_buf[0], b, 8'h00};
							default: p = {mup_pkg::CIN_SYSEX_END3, sx_buf[0], sx_buf[1], b};
						endcase
						sx_on = 0;
						sx_cnt = 0;
					end else if (sx_cnt >= 2) begin
						made = 1;
						p = {mup_pkg::CIN_SYSEX_CONT, sx_buf[0], sx_buf[1], b};
						sx_cnt = 0;
					end else begin
						// flush a partial chunk at the end of a write
						if (eow) begin
							made = 1;
							if (sx_cnt == 0)
								p = {mup_pkg::CIN_SYSEX_CONT, b, 8'h00, 8'h00};
							else
								p = {mup_pkg::CIN_SYSEX_CONT, sx_buf[0], b, 8'h00};
						end
						sx_buf[sx_cnt[0]] = b;
						sx_cnt = sx_cnt + 2'd1;
					end
				end else if (b >= STATUS_MIN) begin
					n = bytes_in_message(b);
					if (n == 1) begin
						made = 1;
						p = {cin_for(b, n), b, 8'h00, 8'h00};
					end else begin
						run_status = b;
						data_left = 2'(n - 1);
					end
				end
			end
			if (eow)
				clear();
			if (made)
				expected_pkts.push_back(p);
		endfunction

		function void check_packet(mup_pkg::mup_pkt_t got);
			mup_pkg::mup_pkt_t exp;
			if (expected_pkts.size() == 0) begin
				fault($sformatf("unexpected packet cin %h bytes %h %h %h",
					got.code_index, got.msg_byte0, got.msg_byte1, got.msg_byte2));
				return;
			end
			exp = expected_pkts.pop_front();
			if (got.code_index !== exp.code_index || got.msg_byte0 !== exp.msg_byte0 ||
					got.msg_byte1 !== exp.msg_byte1 || got.msg_byte2 !== exp.msg_byte2) begin
				fault($sformatf("packet mismatch: exp cin %h bytes %h %h %h, got cin %h bytes %h %h %h",
					exp.code_index, exp.msg_byte0, exp.msg_byte1, exp.msg_byte2,
					got.code_index, got.msg_byte0, got.msg_byte1, got.msg_byte2));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	mup_byte_if midi_in();
	mup_pkt_if  pkt_out();

	midi_to_usb_midi_packetizer_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.midi_in (midi_in),
		.pkt_out (pkt_out)
	);

	packet_scoreboard sb;

	// gap and stall switches; calm forces both off for the tail of the run
	bit          src_gaps;
	bit          sink_stalls;
	bit          calm;
	int unsigned items_sent;
	int unsigned idle_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Sink side: ready drops in random bursts while stalls are enabled.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		pkt_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0 && !calm) begin
				pkt_out.ready = 1'b0;
				stall_left--;
			end else begin
				pkt_out.ready = 1'b1;
				stall_left = 0;
				if (sink_stalls && !calm && $urandom_range(0, 5) == 0)
					stall_left = $urandom_range(1, 15);
			end
		end
	end

	// Monitor: both channels are sampled at the rising edge. The output is checked
	// first; a byte taken at this edge cannot have its packet out before the next one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pkt_out.valid && pkt_out.ready)
				sb.check_packet({pkt_out.code_index, pkt_out.msg_byte0, pkt_out.msg_byte1,
					pkt_out.msg_byte2});
			if (midi_in.valid && midi_in.ready)
				sb.note_byte(midi_in.midi_byte, midi_in.end_of_write);
		end
	end

	// Watchdog: any transaction on either channel restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((midi_in.valid && midi_in.ready) || (pkt_out.valid && pkt_out.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("%t ERROR no transaction for %0d cycles", $realtime, HANG_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	// One byte transaction. Called right after a falling edge and returns right after
	// one, so valid only ever changes on the falling edge.
	task automatic send_byte(input logic [7:0] b, input logic eow);
		if (src_gaps && !calm && $urandom_range(0, 5) == 0) begin
			midi_in.valid = 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		midi_in.valid = 1'b1;
		midi_in.midi_byte = b;
		midi_in.end_of_write = eow;
		do @(posedge clk); while (!midi_in.ready);
		@(negedge clk);
	endtask

	// random byte in a random write; roughly one byte in twenty ends the write
	task automatic feed(input logic [7:0] b);
		send_byte(b, $urandom_range(0, 19) == 0);
	endtask

	// data byte, mostly well formed, sometimes with the top bit set
	function automatic logic [7:0] data_byte();
		return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
			8'($urandom_range(0, 127));
	endfunction

	task automatic hold_until_drained();
		midi_in.valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	// Random message mix: channel and system messages, real time, SysEx of random
	// length (sometimes left open), truncated messages and stray noise.
	task automatic play_random(input int unsigned count);
		logic [7:0]  st;
		int unsigned kind;
		int unsigned len;
		while (items_sent < count) begin
			if (items_sent % 150 == 0) begin
				src_gaps = $urandom_range(0, 1);
				sink_stalls = $urandom_range(0, 1);
			end
			if (items_sent + CALM_TAIL >= count)
				calm = 1'b1;
			if (items_sent == count / 2 && !calm)
				hold_until_drained();
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				// channel voice message
				st = 8'($urandom_range(8'h80, 8'hEF));
				feed(st);
				len = sb.bytes_in_message(st) - 1;
				repeat (len) feed(data_byte());
				items_sent += len + 1;
			end else if (kind < 55) begin
				// system common, including lone end of SysEx
				st = 8'($urandom_range(8'hF1, 8'hF7));
				feed(st);
				len = sb.bytes_in_message(st) - 1;
				repeat (len) feed(data_byte());
				items_sent += len + 1;
			end else if (kind < 65) begin
				feed(8'($urandom_range(mup_pkg::REALTIME_MIN, 8'hFF)));
				items_sent++;
			end else if (kind < 85) begin
				// SysEx; payload may carry real-time or status bytes
				feed(mup_pkg::SYSEX_START);
				len = $urandom_range(0, 9);
				repeat (len) begin
					if ($urandom_range(0, 9) == 0)
						feed(8'($urandom_range(8'hF0, 8'hFF)));
					else
						feed(8'($urandom_range(0, 127)));
				end
				if ($urandom_range(0, 3) != 0) begin
					feed(mup_pkg::SYSEX_END);
					items_sent++;
				end
				items_sent += len + 1;
			end else if (kind < 95) begin
				// noise
				len = $urandom_range(1, 4);
				repeat (len) feed(8'($urandom_range(0, 255)));
				items_sent += len;
			end else begin
				// message cut short by a write boundary (a two-byte one is complete)
				st = 8'($urandom_range(8'h80, 8'hEF));
				feed(st);
				send_byte(data_byte(), 1'b1);
				items_sent += 2;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		midi_in.valid = 1'b0;
		midi_in.midi_byte = 8'h00;
		midi_in.end_of_write = 1'b0;
		src_gaps = 1'b0;
		sink_stalls = 1'b0;
		calm = 1'b0;
		items_sent = 0;
		idle_cycles = 0;
		sb = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: stray data byte is dropped
		send_byte(8'h35, 1'b0);
		// channel messages at data extremes; data is taken whatever its value
		send_byte(8'h80, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hEF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'hFE, 1'b0);
		// system common of each size
		send_byte(mup_pkg::SYS_MTC, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(mup_pkg::SYS_SONG_POS, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'hF6, 1'b0);
		// lone end of SysEx goes out as a one-byte message
		send_byte(mup_pkg::SYSEX_END, 1'b0);
		send_byte(8'hFF, 1'b0);
		// status bytes inside SysEx are payload; ends with a three-byte tail
		send_byte(mup_pkg::SYSEX_START, 1'b0);
		send_byte(8'h7E, 1'b0);
		send_byte(mup_pkg::REALTIME_MIN, 1'b0);
		send_byte(mup_pkg::SYSEX_START, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(mup_pkg::SYSEX_END, 1'b0);
		// end of write flushes an open SysEx chunk of two, then of one
		send_byte(mup_pkg::SYSEX_START, 1'b0);
		send_byte(8'h11, 1'b1);
		send_byte(mup_pkg::SYSEX_START, 1'b1);
		// end of write drops an incomplete message; the next data byte is stray
		send_byte(8'h90, 1'b0);
		send_byte(8'h40, 1'b1);
		send_byte(8'h40, 1'b0);

		// sender holds off until all packets so far are out
		hold_until_drained();

		play_random(RANDOM_ITEMS);

		midi_in.valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		// packets pass the input stage and the result register; give them time to show anything spurious
		repeat (10) @(posedge clk);
		if (sb.pending() != 0)
			sb.fault($sformatf("%0d packets never arrived", sb.pending()));
		if (sb.fault_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### files.f
sv/mup_pkg.sv
sv/mup_if.sv
sv/mup_encoder.sv
sv/midi_to_usb_midi_packetizer_core.sv
sv/mup_checker.sv
dv/midi_to_usb_midi_packetizer_core_test.sv
